// ===== hdl/cprng_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the combined LCG / LFSR / xorshift generator.
// No dependencies.
package cprng_pkg;

  localparam int unsigned WordWidth   = 32;
  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned InDataWidth = 8;

  localparam logic [WordWidth-1:0] LcgMul    = 32'd1664525;
  localparam logic [WordWidth-1:0] LcgAdd    = 32'd1013904223;
  localparam logic [WordWidth-1:0] LfsrTaps  = 32'h8000000b;
  localparam logic [WordWidth-1:0] ShortMask = 32'h00007fff;

  typedef enum logic [CfgIdxWidth-1:0] {
    RegSeedLcg      = 3'd0,
    RegSeedLfsr     = 3'd1,
    RegSeedXsFirst  = 3'd2,
    RegSeedXsSecond = 3'd3,
    RegFullWidth    = 3'd4
  } cfg_reg_e;

  // Complete generator state, used for both the seeds and the live words.
  typedef struct packed {
    logic [WordWidth-1:0] lcg;
    logic [WordWidth-1:0] lfsr;
    logic [WordWidth-1:0] xs_first;
    logic [WordWidth-1:0] xs_second;
  } gen_state_t;

endpackage

// ===== hdl/combined_lcg_lfsr_xorshift_prng_unit.sv =====
`timescale 1ns / 1ps
// Top level of the combined pseudo-random word generator: config registers,
// handshake and output stage. Depends on cprng_pkg and cprng_core.

// Each request item yields one random word: accepting the item advances the
// LCG (one constant 32x32 multiply), the LFSR and the xorshift pair in the
// generator state registers, and when the output register is free it registers
// lfsr - lcg + xs_second, masked to 15 bits unless full width is selected.
// m_axis_tvalid rises once the output register is loaded. The pipeline takes
// one item every clock while the output side is ready. Seed registers take
// effect on the first item after reset or on an item with reseed set. The
// user must write configuration only while no item is in flight (not enforced).
module combined_lcg_lfsr_xorshift_prng_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [cprng_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  logic [cprng_pkg::WordWidth-1:0]   cfg_data_i,
  // request stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [cprng_pkg::InDataWidth-1:0] s_axis_tdata,  // [0] reseed, rest zero
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [cprng_pkg::WordWidth-1:0]   m_axis_tdata   // [31:0] random_value
);

  cprng_pkg::gen_state_t seed_q, gen_state;
  logic                  full_width_q;
  logic                  step_valid_q;
  logic                  out_valid_q;
  logic [cprng_pkg::WordWidth-1:0] out_data_q, out_data_d;
  logic                  in_fire, out_free, stage_move;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q.lcg       <= '0;
      seed_q.lfsr      <= cprng_pkg::WordWidth'(1);
      seed_q.xs_first  <= '0;
      seed_q.xs_second <= cprng_pkg::WordWidth'(1);
      full_width_q     <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        cprng_pkg::RegSeedLcg:      seed_q.lcg       <= cfg_data_i;
        cprng_pkg::RegSeedLfsr:     seed_q.lfsr      <= cfg_data_i;
        cprng_pkg::RegSeedXsFirst:  seed_q.xs_first  <= cfg_data_i;
        cprng_pkg::RegSeedXsSecond: seed_q.xs_second <= cfg_data_i;
        cprng_pkg::RegFullWidth:    full_width_q     <= cfg_data_i[0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Stage one is the generator state itself; stage two the output register.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign stage_move    = step_valid_q && out_free;
  assign s_axis_tready = !step_valid_q || out_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  cprng_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (in_fire),
    .reseed_i (s_axis_tdata[0]),
    .seed_i   (seed_q),
    .state_o  (gen_state)
  );

  always_comb begin
    out_data_d = gen_state.lfsr - gen_state.lcg + gen_state.xs_second;
    if (!full_width_q) begin
      out_data_d = out_data_d & cprng_pkg::ShortMask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_fire) begin
        step_valid_q <= 1'b1;
      end else if (stage_move) begin
        step_valid_q <= 1'b0;
      end
      if (stage_move) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_move) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== hdl/cprng_core.sv =====
`timescale 1ns / 1ps
// Generator state registers and the one-step update of all three generators.
// Depends on cprng_pkg.
module cprng_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic                   reseed_i,
  input  cprng_pkg::gen_state_t  seed_i,
  output cprng_pkg::gen_state_t  state_o
);

  cprng_pkg::gen_state_t state_q, state_d, cur;
  logic                  seeded_q, seeded_d;
  logic [cprng_pkg::WordWidth-1:0] xs_t;

  always_comb begin
    // Load the seeds before stepping on the first item or on request.
    cur = (reseed_i || !seeded_q) ? seed_i : state_q;

    state_d.lcg = cprng_pkg::LcgMul * cur.lcg + cprng_pkg::LcgAdd;

    state_d.lfsr = {cur.lfsr[cprng_pkg::WordWidth-2:0], 1'b0};
    if (cur.lfsr[cprng_pkg::WordWidth-1]) begin
      state_d.lfsr = state_d.lfsr ^ cprng_pkg::LfsrTaps;
    end

    xs_t               = cur.xs_first ^ (cur.xs_first << 2);
    state_d.xs_first   = cur.xs_second;
    state_d.xs_second  = cur.xs_second ^ (cur.xs_second >> 3) ^ xs_t ^ (xs_t >> 7);

    seeded_d = seeded_q | step_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seeded_q <= 1'b0;
    end else begin
      seeded_q <= seeded_d;
    end
  end

  // Advance only on an accepted item.
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for combined_lcg_lfsr_xorshift_prng_unit: a bit-exact predictor
// of the LCG / Galois LFSR / xorshift mix checks every result word.
// Depends on cprng_pkg and the unit's RTL.
module tb_top;

  localparam int unsigned CycleLimit   = 600000;
  localparam int unsigned DrainCycles  = 4;
  localparam int unsigned RandomItems  = 2000;
  localparam logic [31:0] MulConst     = 32'd1664525;
  localparam logic [31:0] AddConst     = 32'd1013904223;
  localparam logic [31:0] TapMask      = 32'h8000000b;
  localparam logic [31:0] LowBitsMask  = 32'h00007fff;
  localparam logic [31:0] AllOnes      = 32'hffffffff;
  localparam int unsigned NumRegSlots  = 1 << cprng_pkg::CfgIdxWidth;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [cprng_pkg::CfgIdxWidth-1:0] cfg_index = '0;
  logic [cprng_pkg::WordWidth-1:0]   cfg_data = '0;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [cprng_pkg::InDataWidth-1:0] s_axis_tdata = '0;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [cprng_pkg::WordWidth-1:0]   m_axis_tdata;

  // predictor state: seed registers, live generator words, width select
  cprng_pkg::gen_state_t seed_regs;
  cprng_pkg::gen_state_t gen_live;
  logic                  gen_seeded;
  logic                  full_width_reg;
  logic [31:0]           expected_words[$];

  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned rx_stall_left = 0;
  bit          tx_idle_on = 1'b0;
  bit          rx_idle_on = 1'b0;

  combined_lcg_lfsr_xorshift_prng_unit dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [0] reseed, rest zero
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)    // [31:0] random_value
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_length();
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] next_random_word(logic reseed);
    logic [31:0] mix;
    if (reseed || !gen_seeded) begin
      gen_live   = seed_regs;
      gen_seeded = 1'b1;
    end
    gen_live.lcg = gen_live.lcg * MulConst + AddConst;
    mix = {gen_live.lfsr[30:0], 1'b0};
    if (gen_live.lfsr[31]) mix ^= TapMask;
    gen_live.lfsr = mix;
    mix = gen_live.xs_first ^ (gen_live.xs_first << 2);
    gen_live.xs_first  = gen_live.xs_second;
    gen_live.xs_second = gen_live.xs_second ^ (gen_live.xs_second >> 3) ^ mix ^ (mix >> 7);
    mix = gen_live.lfsr - gen_live.lcg + gen_live.xs_second;
    if (!full_width_reg) mix &= LowBitsMask;
    return mix;
  endfunction

  // result side: check accepted words, stall at random
  always @(posedge clk) begin
    logic [31:0] want;
    if (rst_n && m_axis_tvalid && m_axis_tready) begin
      if (expected_words.size() == 0) begin
        $error("random_value: unexpected result, expected none, actual 0x%08h", m_axis_tdata);
        fail_count++;
      end else begin
        want = expected_words.pop_front();
        if (m_axis_tdata !== want) begin
          $error("random_value: expected 0x%08h, actual 0x%08h", want, m_axis_tdata);
          fail_count++;
        end
      end
    end
    if (rx_stall_left != 0) begin
      rx_stall_left--;
      m_axis_tready <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
      rx_stall_left = idle_length() - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_request(input logic reseed);
    int unsigned gap;
    gap = (tx_idle_on && $urandom_range(0, 2) == 0) ? idle_length() : 0;
    cfg_valid <= 1'b0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(cprng_pkg::InDataWidth-1){1'b0}}, reseed};
    do @(posedge clk); while (!s_axis_tready);
    expected_words.push_back(next_random_word(reseed));
  endtask

  // hold off until every result is back, then let the pipeline empty
  task automatic settle_idle();
    s_axis_tvalid <= 1'b0;
    cfg_valid     <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_register(input logic [cprng_pkg::CfgIdxWidth-1:0] idx,
                                input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (cprng_pkg::cfg_reg_e'(idx))
      cprng_pkg::RegSeedLcg:      seed_regs.lcg       = data;
      cprng_pkg::RegSeedLfsr:     seed_regs.lfsr      = data;
      cprng_pkg::RegSeedXsFirst:  seed_regs.xs_first  = data;
      cprng_pkg::RegSeedXsSecond: seed_regs.xs_second = data;
      cprng_pkg::RegFullWidth:    full_width_reg      = data[0];
      default: ;
    endcase
  endtask

  // first item after reset loads the reset seeds even without reseed
  task automatic test_reset_seeds();
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
  endtask

  task automatic test_register_extremes();
    int idx;
    settle_idle();
    write_register(cprng_pkg::RegSeedLcg, AllOnes);
    write_register(cprng_pkg::RegSeedLfsr, AllOnes);
    write_register(cprng_pkg::RegSeedXsFirst, AllOnes);
    write_register(cprng_pkg::RegSeedXsSecond, AllOnes);
    write_register(cprng_pkg::RegFullWidth, 32'd1);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    // only bit 0 of the width register is kept
    settle_idle();
    write_register(cprng_pkg::RegFullWidth, 32'hfffffffe);
    send_request(1'b0);
    send_request(1'b1);
    // writes past the last register must not land anywhere
    settle_idle();
    write_register(cprng_pkg::RegFullWidth, 32'd1);
    for (idx = int'(cprng_pkg::RegFullWidth) + 1; idx < NumRegSlots; idx++) begin
      write_register(idx[cprng_pkg::CfgIdxWidth-1:0], AllOnes);
      write_register(idx[cprng_pkg::CfgIdxWidth-1:0], 32'd0);
    end
    send_request(1'b1);
    send_request(1'b0);
  endtask

  // zero LFSR seed and an all-zero xorshift pair stay stuck at zero
  task automatic test_zero_seeds();
    settle_idle();
    write_register(cprng_pkg::RegSeedLcg, 32'd0);
    write_register(cprng_pkg::RegSeedLfsr, 32'd0);
    write_register(cprng_pkg::RegSeedXsFirst, 32'd0);
    write_register(cprng_pkg::RegSeedXsSecond, 32'd0);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    settle_idle();
    write_register(cprng_pkg::RegFullWidth, 32'd0);
    send_request(1'b0);
    send_request(1'b1);
  endtask

  // a new seed waits for the next reseed item
  task automatic test_late_seed_write();
    settle_idle();
    write_register(cprng_pkg::RegSeedLcg, 32'h80000000);
    write_register(cprng_pkg::RegSeedLfsr, 32'h80000000);
    write_register(cprng_pkg::RegSeedXsFirst, 32'h12345678);
    write_register(cprng_pkg::RegSeedXsSecond, 32'h00000001);
    write_register(cprng_pkg::RegFullWidth, 32'd1);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
  endtask

  task automatic test_random_streams();
    int unsigned sent;
    int unsigned run_len;
    int unsigned k;
    int          idx;
    logic [1:0]  mode;
    logic [31:0] value;
    sent = 0;
    while (sent < RandomItems) begin
      settle_idle();
      for (idx = 0; idx < NumRegSlots; idx++) begin
        if ($urandom_range(0, 1) != 0) begin
          case ($urandom_range(0, 7))
            0: value = 32'd0;
            1: value = AllOnes;
            2: value = 32'd1;
            3: value = 32'h80000000;
            default: value = $urandom;
          endcase
          write_register(idx[cprng_pkg::CfgIdxWidth-1:0], value);
        end
      end
      mode       = 2'($urandom_range(0, 3));
      tx_idle_on = mode[0];
      rx_idle_on = mode[1];
      run_len    = $urandom_range(10, 150);
      for (k = 0; k < run_len && sent < RandomItems; k++) begin
        if (k != 0 && $urandom_range(0, 199) == 0) settle_idle();
        if (k == 0) send_request($urandom_range(0, 3) != 0);
        else send_request($urandom_range(0, 31) == 0);
        sent++;
      end
    end
  endtask

  initial begin
    seed_regs      = '{lcg: 32'd0, lfsr: 32'd1, xs_first: 32'd0, xs_second: 32'd1};
    gen_live       = '0;
    gen_seeded     = 1'b0;
    full_width_reg = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    test_reset_seeds();
    test_register_extremes();
    test_zero_seeds();
    test_late_seed_write();
    test_random_streams();
    settle_idle();
    if (fail_count == 0 && expected_words.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
